// ----- hdl/cta_pkg.sv -----
// shared types and constants for the cmyk tone adjust block
// no dependencies; used by cmyk_tone_adjust, its port checker and the testbench
package cta_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned PIX_W      = 3 * CH_W;
    localparam int unsigned OFFSET_W   = 17;
    localparam int unsigned GAIN_W     = 18;
    localparam int unsigned REG_FRAC   = 16;
    localparam int unsigned CFG_DATA_W = 18;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd9830;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 18'd68813;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLACK_OFFSET = 1'b0,
        CFG_INK_GAIN     = 1'b1
    } t_cfg_reg;

endpackage

// ----- hdl/cmyk_tone_adjust.sv -----
// cmyk tone adjust: rgb pixel stream through a cmyk round trip with black offset and ink gain
// depends on cta_pkg (widths, register codes, reset values)

// One RGB pixel per transfer goes in and one adjusted RGB pixel comes out. The block
// takes a new pixel every clock cycle as long as the output side keeps up; a pixel
// passes FRAC_BITS + 7 register stages before it is offered on the output. That
// depth is set by the ink divider, a restoring divider that resolves one quotient
// bit per stage for all three channels in parallel (FRAC_BITS + 1 stages), plus six
// stages for max, scaling and the return to RGB. Each stage holds its own valid bit
// and only stalls when it and every stage after it are full and the output is held,
// so empty slots fill up while a result waits on the output. black_offset and
// ink_gain are both in units of 1/65536 and are written through the plain register
// port; write them only while no pixel is in flight.
module cmyk_tone_adjust #(
    parameter int unsigned FRAC_BITS = 16   // fraction bits of the internal format, 8..24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cta_pkg::PIX_W-1:0]     s_tdata,    // red [7:0], green [15:8], blue [23:16]
    // pixel output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cta_pkg::PIX_W-1:0]     m_tdata,    // out_red [7:0], out_green [15:8],
                                                      // out_blue [23:16]
    // register write port
    input  logic                          i_cfg_we,
    input  logic [cta_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cta_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cta_pkg::*;

    // fixed-point widths: values range over [0, one], so one extra bit
    localparam int unsigned QW  = FRAC_BITS + 1;
    localparam int unsigned DIV = QW;          // divider stages, one quotient bit each
    localparam int unsigned NS  = DIV + 6;     // total pipeline stages
    localparam int unsigned GPW = QW + GAIN_W; // ink times gain product

    localparam logic [QW-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    // max * one / 255 = max * A + max * B / 255, with one = 255 * A + B
    localparam int unsigned ONE_I   = 1 << FRAC_BITS;
    localparam int unsigned KEY_A_I = ONE_I / 255;
    localparam int unsigned KEY_B_I = ONE_I % 255;
    localparam logic [QW-1:0] KEY_A = QW'(KEY_A_I);
    localparam logic [15:0]   KEY_B = 16'(KEY_B_I);

    // stage indexes after the divider
    localparam int unsigned ST_PROD = DIV + 1;   // key partial products, ink times gain
    localparam int unsigned ST_CLMP = DIV + 2;   // key quotient, ink clamp
    localparam int unsigned ST_INV  = DIV + 3;   // one minus key and one minus ink
    localparam int unsigned ST_MUL  = DIV + 4;   // (1 - ink)(1 - key)
    localparam int unsigned ST_OUT  = DIV + 5;   // scale to 8 bits, output register

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] r_black_offset;
    logic [GAIN_W-1:0]   r_ink_gain;
    logic [QW-1:0]       w_offset_fx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_offset <= OFFSET_RESET;
            r_ink_gain     <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_BLACK_OFFSET: r_black_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_INK_GAIN:     r_ink_gain     <= i_cfg_data[GAIN_W-1:0];
                default:          r_ink_gain     <= r_ink_gain;
            endcase
        end
    end

    // offset moved from 1/65536 units into the working format
    generate
        if (FRAC_BITS >= REG_FRAC) begin : g_off_up
            localparam int unsigned OFF_SH = FRAC_BITS - REG_FRAC;
            assign w_offset_fx = QW'(r_black_offset) << OFF_SH;
        end else begin : g_off_dn
            localparam int unsigned OFF_SH = REG_FRAC - FRAC_BITS;
            assign w_offset_fx = QW'(r_black_offset >> OFF_SH);
        end
    endgenerate

    // ------------------------------------------------------------------
    // flow control: a stage loads when it or any later stage has a hole,
    // or when the output transfer completes
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    genvar gk;
    generate
        for (gk = 0; gk < NS; gk++) begin : g_en
            assign w_en[gk] = m_tready | ~(&r_vld[NS-1:gk]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_tready = w_en[0];
    assign m_tvalid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // stage 0: channel max, ink numerators
    // ------------------------------------------------------------------
    logic [CH_W-1:0] w_ch [3];
    logic [CH_W-1:0] n_mx;
    logic [CH_W-1:0] r_mx0;
    logic [CH_W-1:0] r_d0 [3];
    logic            r_z0;

    assign w_ch[0] = s_tdata[0*CH_W +: CH_W];
    assign w_ch[1] = s_tdata[1*CH_W +: CH_W];
    assign w_ch[2] = s_tdata[2*CH_W +: CH_W];

    always_comb begin
        n_mx = w_ch[0];
        if (w_ch[1] > n_mx) n_mx = w_ch[1];
        if (w_ch[2] > n_mx) n_mx = w_ch[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_mx0 <= n_mx;
            r_z0  <= (n_mx == '0);
            for (int c = 0; c < 3; c++) begin
                r_d0[c] <= n_mx - w_ch[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 1..DIV: restoring divider, ink = (max - ch) * one / max
    // the partial remainder always stays below max, so 8 bits hold it
    // ------------------------------------------------------------------
    logic [QW-1:0]   r_dq   [1:DIV][3];
    logic [CH_W-1:0] r_drem [1:DIV][3];
    logic [CH_W-1:0] r_dmx  [1:DIV];
    logic            r_dz   [1:DIV];

    genvar gj;
    generate
        for (gj = 1; gj <= DIV; gj++) begin : g_div
            logic [CH_W:0]   w_rem2 [3];
            logic [QW-1:0]   w_q_in [3];
            logic [CH_W-1:0] w_mx_in;
            logic            w_z_in;
            logic [CH_W-1:0] n_rem  [3];
            logic [QW-1:0]   n_q    [3];

            if (gj == 1) begin : g_first
                assign w_mx_in = r_mx0;
                assign w_z_in  = r_z0;
                for (genvar c = 0; c < 3; c++) begin : g_ch
                    assign w_rem2[c] = {1'b0, r_d0[c]};
                    assign w_q_in[c] = '0;
                end
            end else begin : g_next
                assign w_mx_in = r_dmx[gj-1];
                assign w_z_in  = r_dz[gj-1];
                for (genvar c = 0; c < 3; c++) begin : g_ch
                    assign w_rem2[c] = {r_drem[gj-1][c], 1'b0};
                    assign w_q_in[c] = r_dq[gj-1][c];
                end
            end

            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    if (w_rem2[c] >= {1'b0, w_mx_in}) begin
                        n_rem[c] = CH_W'(w_rem2[c] - {1'b0, w_mx_in});
                        n_q[c]   = {w_q_in[c][QW-2:0], 1'b1};
                    end else begin
                        n_rem[c] = w_rem2[c][CH_W-1:0];
                        n_q[c]   = {w_q_in[c][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[gj]) begin
                    r_dmx[gj] <= w_mx_in;
                    r_dz[gj]  <= w_z_in;
                    for (int c = 0; c < 3; c++) begin
                        r_drem[gj][c] <= n_rem[c];
                        r_dq[gj][c]   <= n_q[c];
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // key partial products and ink gain; a black pixel has no ink
    // ------------------------------------------------------------------
    logic [QW-1:0]  r_pa;
    logic [15:0]    r_pb;
    logic [GPW-1:0] r_gp [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_pa <= QW'(r_dmx[DIV]) * KEY_A;
            r_pb <= 16'(r_dmx[DIV]) * KEY_B;
            for (int c = 0; c < 3; c++) begin
                r_gp[c] <= r_dz[DIV] ? '0 : GPW'(r_dq[DIV][c]) * GPW'(r_ink_gain);
            end
        end
    end

    // ------------------------------------------------------------------
    // key quotient max * one / 255, ink clamped to one
    // the small remainder term is divided by 255 exactly for any 16-bit value below 65535
    // ------------------------------------------------------------------
    logic [16:0]       w_pb_sum;
    logic [QW+1:0]     w_ink_raw [3];
    logic [QW-1:0]     r_kq;
    logic [QW-1:0]     r_ink [3];

    assign w_pb_sum = 17'(r_pb) + 17'(r_pb[15:8]) + 17'd1;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ink_raw[c] = r_gp[c][GPW-1:REG_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_CLMP]) begin
            r_kq <= r_pa + QW'(w_pb_sum[16:8]);
            for (int c = 0; c < 3; c++) begin
                r_ink[c] <= (w_ink_raw[c] > (QW+2)'(ONE_FX)) ? ONE_FX
                                                               : w_ink_raw[c][QW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // one minus adjusted key is max(kq - offset, 0); one minus each ink
    // ------------------------------------------------------------------
    logic [QW-1:0] r_ikey;
    logic [QW-1:0] r_iink [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_INV]) begin
            r_ikey <= (r_kq >= w_offset_fx) ? (r_kq - w_offset_fx) : '0;
            for (int c = 0; c < 3; c++) begin
                r_iink[c] <= ONE_FX - r_ink[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // t = (1 - ink)(1 - key), truncated
    // ------------------------------------------------------------------
    logic [2*QW-1:0] w_tprod [3];
    logic [QW-1:0]   r_t [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_tprod[c] = (2*QW)'(r_iink[c]) * (2*QW)'(r_ikey);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            for (int c = 0; c < 3; c++) begin
                r_t[c] <= w_tprod[c][FRAC_BITS +: QW];
            end
        end
    end

    // ------------------------------------------------------------------
    // channel = t * 255 / one; t never exceeds one, so 8 bits hold it
    // ------------------------------------------------------------------
    logic [QW+7:0]   w_t255 [3];
    logic [CH_W-1:0] r_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_t255[c] = {r_t[c], 8'b0} - (QW+8)'(r_t[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= w_t255[c][FRAC_BITS +: CH_W];
            end
        end
    end

    assign m_tdata = {r_out[2], r_out[1], r_out[0]};

endmodule

// ----- hdl/cta_checker.sv -----
// port-level checks for cmyk_tone_adjust, attached by bind
// depends on cta_pkg (port widths)
module cta_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [cta_pkg::PIX_W-1:0]      s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cta_pkg::PIX_W-1:0]      m_tdata,
    input logic                           i_cfg_we,
    input logic [cta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [cta_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cta_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer dropped while stalled");

    // a stalled result keeps its pixel
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output pixel changed while stalled");

    // input is only refused when the pipeline is full behind a stalled output
    a_back_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without output back-pressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind cmyk_tone_adjust cta_checker u_cta_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for cmyk_tone_adjust: pixel stream in, adjusted pixel stream out
// depends on cta_pkg and the cmyk_tone_adjust rtl; has its own fixed-point predictor

module tb_top;
    import cta_pkg::*;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned PIPE_DEPTH  = FRAC_BITS + 7;   // register stages inside the block
    localparam int unsigned PHASE_ITEMS = 106;
    localparam int unsigned HOLD_CYCLES = 100;              // long receiver hold-off
    localparam int unsigned IDLE_LIMIT  = 2000;             // watchdog, cycles with no transfer
    localparam logic [63:0] ONE         = 64'd1 << FRAC_BITS;

    // red in the low byte, as on tdata
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    // keeps the register copies and the queue of adjusted pixels still to come out
    class tone_scoreboard;
        logic [OFFSET_W-1:0] black_offset;
        logic [GAIN_W-1:0]   ink_gain;
        t_pixel              adjusted_q[$];
        int unsigned         failures;
        int unsigned         pixels_in;
        int unsigned         pixels_out;

        function new();
            black_offset = OFFSET_RESET;
            ink_gain     = GAIN_RESET;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BLACK_OFFSET: black_offset = data[OFFSET_W-1:0];
                CFG_INK_GAIN:     ink_gain     = data[GAIN_W-1:0];
                default:          ;
            endcase
        endfunction

        // rgb -> cmyk, offset and gain, back to rgb, every step truncating
        function t_pixel tone_adjust(t_pixel px);
            logic [63:0] ch [3];
            logic [63:0] res [3];
            logic [63:0] mx, key, off, ink, t;
            t_pixel      adj;
            ch[0] = px.red;
            ch[1] = px.green;
            ch[2] = px.blue;
            mx = ch[0];
            if (ch[1] > mx) mx = ch[1];
            if (ch[2] > mx) mx = ch[2];
            key = ONE - ((mx << FRAC_BITS) / 255);
            if (FRAC_BITS >= REG_FRAC)
                off = 64'(black_offset) << (FRAC_BITS - REG_FRAC);
            else
                off = 64'(black_offset) >> (REG_FRAC - FRAC_BITS);
            key = key + off;
            if (key > ONE) key = ONE;
            for (int i = 0; i < 3; i++) begin
                // black pixel: all inks stay zero
                ink = (mx == 0) ? 64'd0 : ((mx - ch[i]) << FRAC_BITS) / mx;
                ink = (ink * 64'(ink_gain)) >> REG_FRAC;
                if (ink > ONE) ink = ONE;
                t = ((ONE - ink) * (ONE - key)) >> FRAC_BITS;
                res[i] = (t * 255) >> FRAC_BITS;
                if (res[i] > 255) res[i] = 255;
            end
            adj.red   = res[0][7:0];
            adj.green = res[1][7:0];
            adj.blue  = res[2][7:0];
            return adj;
        endfunction

        function void note_pixel(t_pixel px);
            adjusted_q.push_back(tone_adjust(px));
            pixels_in++;
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            pixels_out++;
            if (adjusted_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected output pixel r=%0d g=%0d b=%0d",
                             $realtime, got.red, got.green, got.blue);
                return;
            end
            want = adjusted_q.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display({"%0t: pixel %0d mismatch: expected r=%0d g=%0d b=%0d,",
                              " got r=%0d g=%0d b=%0d"},
                             $realtime, pixels_out, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int unsigned depth();
            return adjusted_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;     // red [7:0], green [15:8], blue [23:16]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;     // out_red [7:0], out_green [15:8], out_blue [23:16]
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tone_scoreboard sb = new();

    bit          calm;          // last part of the run: no idling on either side
    bit          hold_out;      // request for one long receiver hold-off
    int unsigned idle_cycles;
    int unsigned settings_used;

    cmyk_tone_adjust #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // output side: check every transfer against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_pixel(t_pixel'(m_tdata));
    end

    // watchdog: too many cycles without any transfer or register write ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d pixels still expected",
                         $realtime, idle_cycles, sb.depth());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request, none once calm
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                // long enough for the pipeline to fill and push back on the input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic t_pixel rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // mix of corner values, grays, saturated channels, dark pixels and fully random pixels
    function automatic t_pixel random_pixel();
        logic [7:0] corner [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
        t_pixel     px;
        px = t_pixel'(PIX_W'($urandom));
        case ($urandom_range(0, 7))
            0: px = rgb(corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
                        corner[$urandom_range(0, 3)]);
            1: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: px.red   = 8'hFF;
                    1: px.green = 8'hFF;
                    default: px.blue = 8'hFF;
                endcase
            end
            3: begin                                    // dark pixel, small max
                px.red   = px.red & 8'h0F;
                px.green = px.green & 8'h0F;
                px.blue  = px.blue & 8'h0F;
            end
            default: ;
        endcase
        return px;
    endfunction

    // one pixel transfer, with an optional random gap in front of it
    task automatic send_pixel(t_pixel px);
        int unsigned gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge i_clk); while (!s_tready);
        sb.note_pixel(px);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // stop offering pixels and let the pipeline run empty
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.depth() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] offset_val;
        logic [CFG_DATA_W-1:0] gain_val;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BLACK_OFFSET;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pixels under the reset settings: black, white, primaries,
        // tiny max, near-white, alternating bit patterns and mixed values
        settings_used = 1;
        send_pixel(rgb(8'd0,   8'd0,   8'd0));
        send_pixel(rgb(8'd255, 8'd255, 8'd255));
        send_pixel(rgb(8'd255, 8'd0,   8'd0));
        send_pixel(rgb(8'd0,   8'd255, 8'd0));
        send_pixel(rgb(8'd0,   8'd0,   8'd255));
        send_pixel(rgb(8'd1,   8'd0,   8'd0));
        send_pixel(rgb(8'd0,   8'd0,   8'd1));
        send_pixel(rgb(8'd1,   8'd1,   8'd1));
        send_pixel(rgb(8'd255, 8'd254, 8'd253));
        send_pixel(rgb(8'hAA,  8'h55,  8'hAA));
        send_pixel(rgb(8'h55,  8'hAA,  8'h55));
        send_pixel(rgb(8'd128, 8'd127, 8'd0));
        send_pixel(rgb(8'd254, 8'd1,   8'd128));
        send_pixel(rgb(8'd37,  8'd200, 8'd99));

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin                                // no offset, inks wiped out
                    offset_val = '0;
                    gain_val   = '0;
                end
                1: begin                                // offset saturates key, gain two
                    offset_val = 18'd65536;
                    gain_val   = 18'd131072;
                end
                2: begin                                // all bits set, upper offset bit dropped
                    offset_val = 18'h3FFFF;
                    gain_val   = 18'h3FFFF;
                end
                3: begin                                // unity gain
                    offset_val = '0;
                    gain_val   = 18'd65536;
                end
                4: begin
                    offset_val = CFG_DATA_W'($urandom_range(0, 65536));
                    gain_val   = CFG_DATA_W'($urandom_range(0, 131072));
                end
                default: begin
                    offset_val = CFG_DATA_W'($urandom_range(0, 16384));
                    gain_val   = CFG_DATA_W'($urandom_range(32768, 98304));
                end
            endcase
            write_reg(CFG_BLACK_OFFSET, offset_val);
            write_reg(CFG_INK_GAIN, gain_val);
            settings_used++;
            if (p == 1) hold_out = 1'b1;
            if (p == 5) calm = 1'b1;
            repeat (PHASE_ITEMS) send_pixel(random_pixel());
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("covered %0d register settings, %0d pixels sent, %0d pixels checked",
                 settings_used, sb.pixels_in, sb.pixels_out);
        $display("%0d failures, %0d pixels never came out", sb.failures, sb.depth());
        if (sb.failures == 0 && sb.depth() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
